@@ design/wfcv_pkg.sv @@
// ----------------------------------------------------------------------------
// wfcv_pkg
// Shared types, constants and the byte-wise CRC step for the waveform image
// validator.
// ----------------------------------------------------------------------------
package wfcv_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned POS_W    = 19;
   localparam int unsigned STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [POS_W-1:0]    pos_type;

   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_LOADED     = 3'd1;
   localparam status_type STATUS_BAD_FORMAT = 3'd2;
   localparam status_type STATUS_TOO_LONG   = 3'd3;
   localparam status_type STATUS_CRC_FAIL   = 3'd4;

   localparam word_type CRC_POLY   = 32'h04C1_0DB7;
   localparam word_type LENGTH_CAP = 32'h0004_0000;
   localparam word_type HEADER_LEN = 32'd16;
   localparam pos_type  MAX_LENGTH_RESET = 19'h4_0000;

   // Decision produced by the check core for one transfer.
   typedef struct packed {
      logic       emit;
      status_type status;
      word_type   computed_crc;
      word_type   stored_crc;
   } result_type;

   // Expected header magic, indexed by byte position 4..15 (low 4 bits).
   function automatic logic [7:0] magic_byte(input logic [3:0] pos);
      logic [7:0] m;
      case (pos)
         4'd4:    m = 8'h72;
         4'd5:    m = 8'h6B;
         4'd6:    m = 8'h66;
         4'd7:    m = 8'h20;
         4'd8:    m = 8'h77;
         4'd9:    m = 8'h61;
         4'd10:   m = 8'h76;
         4'd11:   m = 8'h65;
         4'd12:   m = 8'h66;
         4'd13:   m = 8'h6F;
         4'd14:   m = 8'h72;
         4'd15:   m = 8'h6D;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   // MSB-first 32-bit CRC update over one byte, polynomial 0x04C10DB7.
   function automatic word_type crc_byte(input word_type crc, input logic [7:0] b);
      word_type c;
      c = crc ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ design/wfcv_if.sv @@
// ----------------------------------------------------------------------------
// wfcv channel interfaces
// Valid/ready channels for image bytes and for validation status.
// ----------------------------------------------------------------------------
interface wfcv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface wfcv_rsp_if;
   logic                 valid;
   logic                 ready;
   wfcv_pkg::status_type status;
   wfcv_pkg::word_type   computed_crc;
   wfcv_pkg::word_type   stored_crc;

   modport source (output valid, output status, output computed_crc, output stored_crc,
                   input ready);
   modport sink   (input valid, input status, input computed_crc, input stored_crc,
                   output ready);
endinterface

@@ design/wfcv_check_core.sv @@
// ----------------------------------------------------------------------------
// wfcv_check_core
// Image parsing state: length, magic, running CRC, stored CRC and decision.
// ----------------------------------------------------------------------------
module wfcv_check_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   first_byte,
   input  wfcv_pkg::pos_type      max_length,
   output wfcv_pkg::result_type   result
);
   import wfcv_pkg::*;

   logic     loaded_ff,  loaded_in;
   logic     decided_ff, decided_in;
   pos_type  pos_ff,     pos_in;
   word_type len_ff,     len_in;
   word_type crc_ff,     crc_in;
   word_type rd_ff,      rd_in;

   pos_type    pos;
   word_type   pos_ext;
   word_type   len_new;
   word_type   crc_new;
   word_type   rd_new;
   logic       covered;
   logic [1:0] k;
   result_type res;

   always_comb begin
      pos_ext    = '0;
      len_new    = '0;
      crc_new    = '0;
      rd_new     = '0;
      covered    = 1'b0;
      k          = '0;
      pos        = first_byte ? '0 : pos_ff;
      loaded_in  = loaded_ff;
      decided_in = decided_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      rd_in      = rd_ff;
      res        = '0;

      if (first_byte && loaded_ff) begin
         res.emit   = 1'b1;
         res.status = STATUS_LOADED;
         decided_in = 1'b1;
      end else if (first_byte || !decided_ff) begin
         pos_ext = {{(DATA_W-POS_W){1'b0}}, pos};
         len_new = first_byte ? '0 : len_ff;
         crc_new = first_byte ? '0 : crc_ff;
         rd_new  = first_byte ? '0 : rd_ff;
         decided_in = 1'b0;

         if (pos < POS_W'(4)) begin
            len_new[8*pos[1:0] +: 8] = data_byte;
         end

         covered = (pos < POS_W'(16)) || (pos_ext < len_new);
         if (covered) begin
            crc_new = crc_byte(crc_new, data_byte);
         end else begin
            k = pos[1:0] - len_new[1:0];
            rd_new[8*k +: 8] = rd_new[8*k +: 8] | data_byte;
         end

         pos_in = pos + POS_W'(1);
         len_in = len_new;
         crc_in = crc_new;
         rd_in  = rd_new;

         res.computed_crc = crc_new;
         if (pos >= POS_W'(4) && pos < POS_W'(16) && data_byte != magic_byte(pos[3:0])) begin
            res.emit   = 1'b1;
            res.status = STATUS_BAD_FORMAT;
         end else if (pos == POS_W'(15) && (len_new[31] ||
                      len_new > {{(DATA_W-POS_W){1'b0}}, max_length} ||
                      len_new > LENGTH_CAP)) begin
            res.emit   = 1'b1;
            res.status = STATUS_TOO_LONG;
         end else if (pos == POS_W'(15) && len_new < HEADER_LEN) begin
            res.emit   = 1'b1;
            res.status = STATUS_BAD_FORMAT;
         end else if (!covered && pos_ext == len_new + 32'd3) begin
            res.emit       = 1'b1;
            res.stored_crc = rd_new;
            if (rd_new == crc_new) begin
               res.status = STATUS_OK;
               loaded_in  = 1'b1;
            end else begin
               res.status = STATUS_CRC_FAIL;
            end
         end

         if (res.emit) begin
            decided_in = 1'b1;
         end
      end
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff  <= 1'b0;
         decided_ff <= 1'b1;
         pos_ff     <= '0;
         len_ff     <= '0;
         crc_ff     <= '0;
         rd_ff      <= '0;
      end else if (step) begin
         loaded_ff  <= loaded_in;
         decided_ff <= decided_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         crc_ff     <= crc_in;
         rd_ff      <= rd_in;
      end
   end

endmodule

@@ design/waveform_file_crc_validator.sv @@
// ----------------------------------------------------------------------------
// waveform_file_crc_validator
// Streams a waveform image one byte per transfer, checks header, length and
// a 32-bit CRC, and returns one status transfer per image.
// ----------------------------------------------------------------------------
// Takes one image byte per clock cycle unless a waiting status stalls it.
// A byte passes an input register, then the parsing and CRC logic (one
// byte-wide CRC step) updates the image state and loads the result
// register, from which the status of the byte that decides the image is
// presented. Bytes that decide nothing give no status transfer. A waiting
// status stalls the byte behind it only once the input register is also
// full. max_length is written at csr addresses 0-3; the user must write it
// only while no image byte is in flight, as the block does not enforce this.
module waveform_file_crc_validator (
   input  logic                clock,
   input  logic                reset,
   wfcv_req_if.sink            req_chan,
   wfcv_rsp_if.source          rsp_chan,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import wfcv_pkg::*;

   localparam logic ADDR_MAX_LENGTH = 1'b0;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   pos_type    max_len_ff;
   logic       advance;
   logic       csr_write;
   result_type core_res;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && core_res.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   wfcv_check_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .max_length (max_len_ff),
      .result     (core_res)
   );

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_MAX_LENGTH)
                       ? {{(32-POS_W){1'b0}}, max_len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= MAX_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write && csr_paddr[2] == ADDR_MAX_LENGTH) begin
            max_len_ff <= csr_pwdata[POS_W-1:0];
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.data_byte;
         in_first_ff <= req_chan.first_byte;
      end
      if (advance && core_res.emit) begin
         out_ff <= core_res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.computed_crc = out_ff.computed_crc;
   assign rsp_chan.stored_crc   = out_ff.stored_crc;

endmodule
